// File: rtl/owst_pkg.sv
// ----------------------------------------------------------------------------
// owst_pkg
// Shared types and constants for the one-wire test-command slave.
// ----------------------------------------------------------------------------
package owst_pkg;

  localparam int ReplyBytes = 4;
  localparam int RbW = (ReplyBytes > 1) ? $clog2(ReplyBytes) : 1;
  localparam int CntW = 12;
  localparam logic [CntW-1:0] CntMax = 12'hFFF;
  localparam logic [7:0] OkCode = 8'h20;

  localparam logic [7:0] CmdClear   = 8'h09;
  localparam logic [7:0] CmdSetAll  = 8'h10;
  localparam logic [7:0] CmdDefault = 8'h11;
  localparam logic [7:0] CmdTrigger = 8'h12;
  localparam logic [7:0] CmdCount   = 8'h13;
  localparam logic [7:0] CmdMap     = 8'h14;
  localparam logic [7:0] CmdLeds    = 8'h15;
  localparam logic [7:0] CmdInMin   = 8'h80;

  localparam logic [2:0] RegResetMin = 3'd0;
  localparam logic [2:0] RegBitOne   = 3'd1;
  localparam logic [2:0] RegPWait    = 3'd2;
  localparam logic [2:0] RegPLen     = 3'd3;
  localparam logic [2:0] RegPRecov   = 3'd4;
  localparam logic [2:0] RegWrOne    = 3'd5;
  localparam logic [2:0] RegWrZero   = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PWAIT, PH_PPULL, PH_PRECOV, PH_RX, PH_TXWAIT, PH_TXHOLD, PH_TXREL
  } phase_t;

  // One accepted tick as it moves from the front part to the back part.
  typedef struct packed {
    logic       line_level;
    logic [2:0] sense;
  } sample_t;

  typedef struct packed {
    logic       line_pull;
    logic [4:0] stimulus_pins;
    logic [8:0] led_pins;
    logic       command_done;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0] reset_min_low;
    logic [CntW-1:0] bit_one_max_low;
    logic [CntW-1:0] presence_wait;
    logic [CntW-1:0] presence_length;
    logic [CntW-1:0] presence_recovery;
    logic [CntW-1:0] write_one_hold;
    logic [CntW-1:0] write_zero_hold;
  } cfg_t;

endpackage

// File: rtl/one_wire_slave_test_commands_top.sv
// ----------------------------------------------------------------------------
// one_wire_slave_test_commands_top
// One-wire test-jig slave with command decoding and fault tracking.
// ----------------------------------------------------------------------------
// Each input request on s_axis carries one bus sample and three sensed pin
// levels; each produces exactly one result request on m_axis with the bus
// pull, stimulus pins, LED pins and a command-done flag.
// The front part queues samples in a two-entry FIFO; the back part runs the
// bus state machine and registers each result. A result is registered at the
// edge where its sample leaves the queue, so each sample passes through a FIFO entry and
// then the result register; one sample is taken every cycle while nothing stalls.
// Timing registers are written through cfg_we/cfg_index/cfg_data. The user must write them only
// while idle; the block does not enforce it. Reset restores the default timings and clears all
// state, the FIFO and the result-valid flag.
// When the receiver stalls, the result register holds, the FIFO fills to two
// samples and s_axis_tready stays low until the result is taken.
// ----------------------------------------------------------------------------
module one_wire_slave_test_commands_top import owst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // line_level, sense_immobiliser, sense_output_a, sense_tag_led
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // line_pull, stimulus_pins[4:0], led_pins[8:0], command_done
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  cfg_t    cfg;
  sample_t q_data;
  logic    q_valid;
  logic    q_ready;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{reset_min_low: 12'd380, bit_one_max_low: 12'd20, presence_wait: 12'd26,
               presence_length: 12'd260, presence_recovery: 12'd46,
               write_one_hold: 12'd15, write_zero_hold: 12'd80};
    end else if (cfg_we) begin
      case (cfg_index)
        RegResetMin: cfg.reset_min_low     <= cfg_data;
        RegBitOne:   cfg.bit_one_max_low   <= cfg_data;
        RegPWait:    cfg.presence_wait     <= cfg_data;
        RegPLen:     cfg.presence_length   <= cfg_data;
        RegPRecov:   cfg.presence_recovery <= cfg_data;
        RegWrOne:    cfg.write_one_hold    <= cfg_data;
        RegWrZero:   cfg.write_zero_hold   <= cfg_data;
        default: ;
      endcase
    end
  end

  owst_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .q_valid, .q_ready, .q_data
  );

  owst_back u_back (
    .clk, .rst, .cfg,
    .q_valid, .q_ready, .q_data,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
  );

  assign m_axis_tdata = {res.command_done, res.led_pins, res.stimulus_pins, res.line_pull};

endmodule

// File: rtl/owst_front.sv
// ----------------------------------------------------------------------------
// owst_front
// Accepts input ticks, unpacks them and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module owst_front import owst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  output logic       q_valid,
  input  logic       q_ready,
  output sample_t    q_data
);

  sample_t     mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{line_level: in_data[0], sense: in_data[3:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("bad queue count");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop from empty queue");

endmodule

// File: rtl/owst_back.sv
// ----------------------------------------------------------------------------
// owst_back
// Protocol engine: bus timing, command execution and the output register.
// ----------------------------------------------------------------------------
module owst_back import owst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  sample_t     q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data
);

  phase_t          phase, phase_next;
  logic [CntW-1:0] low_ticks, low_ticks_next;
  logic [CntW-1:0] wait_ticks, wait_ticks_next;
  logic [7:0]      command_shift, command_shift_next;
  logic [3:0]      bit_index, bit_index_next;
  logic [7:0]      reply_bytes [ReplyBytes];
  logic [7:0]      reply_bytes_next [ReplyBytes];
  logic [RbW:0]    reply_byte_index, reply_byte_index_next;
  logic [8:0]      fault_flags, fault_flags_next;
  logic [2:0]      default_levels, default_levels_next;
  logic [2:0]      triggered_levels, triggered_levels_next;
  logic [4:0]      stimulus_reg, stimulus_reg_next;
  logic [8:0]      led_reg, led_reg_next;
  logic            done;
  logic            step;
  logic [7:0]      cmd;
  logic            reply;
  logic            rx_bit;
  logic [2:0]      diff;
  logic            tx_bit;
  logic [CntW-1:0] hold_n;
  phase_t          target;

  assign q_ready = !out_valid || out_ready;
  assign step    = q_valid && q_ready;
  assign rx_bit  = (low_ticks <= cfg.bit_one_max_low);
  assign cmd     = {rx_bit, command_shift[7:1]};
  assign tx_bit  = reply_bytes[reply_byte_index[RbW-1:0]][bit_index[2:0]];
  assign hold_n  = tx_bit ? cfg.write_one_hold : cfg.write_zero_hold;

  always_comb begin
    phase_next            = phase;
    low_ticks_next        = low_ticks;
    wait_ticks_next       = wait_ticks;
    command_shift_next    = command_shift;
    bit_index_next        = bit_index;
    reply_bytes_next      = reply_bytes;
    reply_byte_index_next = reply_byte_index;
    fault_flags_next      = fault_flags;
    default_levels_next   = default_levels;
    triggered_levels_next = triggered_levels;
    stimulus_reg_next     = stimulus_reg;
    led_reg_next          = led_reg;
    done                  = 1'b0;
    reply                 = 1'b0;
    diff                  = default_levels ^ q_data.sense;
    target                = PH_IDLE;

    unique case (phase)
      PH_IDLE: begin
        if (!q_data.line_level) begin
          if (low_ticks != CntMax) low_ticks_next = low_ticks + 1'b1;
        end else if (low_ticks != '0) begin
          low_ticks_next = '0;
          if (low_ticks > cfg.reset_min_low) target = PH_PWAIT;
        end
      end
      PH_PWAIT, PH_PPULL, PH_PRECOV: begin
        if (wait_ticks <= 12'd1) begin
          wait_ticks_next = '0;
          target = (phase == PH_PWAIT) ? PH_PPULL :
                   (phase == PH_PPULL) ? PH_PRECOV : PH_RX;
        end else begin
          wait_ticks_next = wait_ticks - 1'b1;
        end
      end
      PH_RX: begin
        if (!q_data.line_level) begin
          if (low_ticks != CntMax) low_ticks_next = low_ticks + 1'b1;
        end else if (low_ticks != '0) begin
          command_shift_next = cmd;
          low_ticks_next     = '0;
          bit_index_next     = bit_index + 1'b1;
          if (bit_index >= 4'd7) begin
            done = 1'b1;
            unique case (cmd)
              CmdClear: begin
                stimulus_reg_next = '0; fault_flags_next = '0; led_reg_next = '0;
                reply_bytes_next[0] = OkCode; reply = 1'b1;
              end
              CmdSetAll: begin
                stimulus_reg_next = 5'h1F;
                reply_bytes_next[0] = OkCode; reply = 1'b1;
              end
              CmdDefault: begin
                default_levels_next = ~q_data.sense;
                reply_bytes_next[0] = OkCode; reply = 1'b1;
              end
              CmdTrigger: begin
                triggered_levels_next = q_data.sense;
                reply_bytes_next[0] = OkCode; reply = 1'b1;
                fault_flags_next = {diff[1], diff[2], diff[0], fault_flags[5:0]};
              end
              CmdCount: begin
                reply_bytes_next[0] = 8'(fault_flags[6]) + 8'(fault_flags[7])
                                      + 8'(fault_flags[8]);
                reply = 1'b1;
              end
              CmdMap: begin
                if (fault_flags[6]) reply_bytes_next[0] = 8'd1;
                if (fault_flags[7] && ReplyBytes > 1) reply_bytes_next[1] = 8'd1;
                if (fault_flags[8] && ReplyBytes > 2) reply_bytes_next[2] = 8'd1;
                reply = 1'b1;
              end
              CmdLeds: led_reg_next = fault_flags;
              default: begin
                if (cmd > CmdInMin) begin
                  if (cmd[0]) led_reg_next[7] = ~led_reg[7];
                  fault_flags_next = fault_flags | {3'b000, cmd[5:0]};
                end
              end
            endcase
            target = reply ? PH_TXWAIT : PH_IDLE;
          end
        end
      end
      PH_TXWAIT: begin
        if (!q_data.line_level) begin
          if (hold_n == '0) phase_next = PH_TXREL;
          else begin
            phase_next = PH_TXHOLD;
            wait_ticks_next = hold_n;
          end
        end
      end
      PH_TXHOLD: begin
        if (wait_ticks <= 12'd1) begin
          wait_ticks_next = '0;
          phase_next = PH_TXREL;
        end else begin
          wait_ticks_next = wait_ticks - 1'b1;
        end
      end
      PH_TXREL: begin
        if (q_data.line_level) begin
          if (bit_index >= 4'd7) begin
            bit_index_next = '0;
            if (reply_byte_index + 1'b1 >= (RbW+1)'(ReplyBytes)) begin
              reply_byte_index_next = '0;
              low_ticks_next = '0;
              phase_next = PH_IDLE;
            end else begin
              reply_byte_index_next = reply_byte_index + 1'b1;
              phase_next = PH_TXWAIT;
            end
          end else begin
            bit_index_next = bit_index + 1'b1;
            phase_next = PH_TXWAIT;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    // Phase entry, skipping presence phases whose length is zero.
    if (target != PH_IDLE || done) begin
      if (target == PH_PWAIT && cfg.presence_wait != '0) begin
        phase_next = PH_PWAIT; wait_ticks_next = cfg.presence_wait;
      end else if ((target == PH_PWAIT || target == PH_PPULL)
                   && cfg.presence_length != '0) begin
        phase_next = PH_PPULL; wait_ticks_next = cfg.presence_length;
      end else if ((target == PH_PWAIT || target == PH_PPULL || target == PH_PRECOV)
                   && cfg.presence_recovery != '0) begin
        phase_next = PH_PRECOV; wait_ticks_next = cfg.presence_recovery;
      end else if (target == PH_PWAIT || target == PH_PPULL || target == PH_PRECOV
                   || target == PH_RX) begin
        phase_next = PH_RX; low_ticks_next = '0;
        command_shift_next = '0; bit_index_next = '0;
      end else if (target == PH_TXWAIT) begin
        phase_next = PH_TXWAIT; low_ticks_next = '0;
        bit_index_next = '0; reply_byte_index_next = '0;
      end else begin
        phase_next = PH_IDLE; low_ticks_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      low_ticks        <= '0;
      wait_ticks       <= '0;
      command_shift    <= '0;
      bit_index        <= '0;
      reply_byte_index <= '0;
      fault_flags      <= '0;
      default_levels   <= '0;
      triggered_levels <= '0;
      stimulus_reg     <= '0;
      led_reg          <= '0;
      out_valid        <= 1'b0;
      for (int i = 0; i < ReplyBytes; i++) reply_bytes[i] <= '0;
    end else begin
      if (step) begin
        phase            <= phase_next;
        low_ticks        <= low_ticks_next;
        wait_ticks       <= wait_ticks_next;
        command_shift    <= command_shift_next;
        bit_index        <= bit_index_next;
        reply_bytes      <= reply_bytes_next;
        reply_byte_index <= reply_byte_index_next;
        fault_flags      <= fault_flags_next;
        default_levels   <= default_levels_next;
        triggered_levels <= triggered_levels_next;
        stimulus_reg     <= stimulus_reg_next;
        led_reg          <= led_reg_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= '{line_pull: (phase_next == PH_PPULL || phase_next == PH_TXHOLD),
                    stimulus_pins: stimulus_reg_next,
                    led_pins: led_reg_next,
                    command_done: done};
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_reply_idx: assert property (@(posedge clk) disable iff (rst)
    reply_byte_index < (RbW+1)'(ReplyBytes)) else $error("reply index out of range");
  a_bit_idx: assert property (@(posedge clk) disable iff (rst)
    bit_index <= 4'd8) else $error("bit index out of range");
  a_done_pull: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.command_done |-> !out_data.line_pull)
    else $error("pull on command tick");

endmodule
